// ===== design/hbfie_pkg.sv =====
// ----------------------------------------------------------------------------
// Header bit-field package
// Operation codes, field limits and the control bundle shared by the
// field checker and the header store.
// ----------------------------------------------------------------------------
package hbfie_pkg;

   localparam int unsigned BYTE_BITS = 8;
   localparam int unsigned FIELD_MAX = 32;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef struct packed {
      logic        clr_en;
      logic        wr_en;
      logic        rd_en;
      logic        err;
      logic [31:0] len_mask;
   } ctrl_type;

endpackage

// ===== design/hbfie_check.sv =====
// ----------------------------------------------------------------------------
// Header bit-field checker
// Decodes one transaction: validates the field bounds and the write data
// width, and derives the field mask and the store shift amount.
// ----------------------------------------------------------------------------
module hbfie_check #(
   parameter int unsigned BUFFER_BYTES = 16
) (
   input  logic [1:0]                                     operation,
   input  logic [6:0]                                     start_bit,
   input  logic [6:0]                                     end_bit,
   input  logic [31:0]                                    field_value,
   output hbfie_pkg::ctrl_type                            ctrl,
   output logic [$clog2(BUFFER_BYTES*hbfie_pkg::BYTE_BITS)-1:0] shamt
);

   localparam int unsigned NB = BUFFER_BYTES * hbfie_pkg::BYTE_BITS;
   localparam int unsigned SW = $clog2(NB);
   localparam logic [SW-1:0] LAST_BIT = SW'(NB - 1);
   localparam logic [9:0]    NB_BITS  = 10'(NB);

   logic [7:0]  diff;
   logic [7:0]  len;
   logic        order_bad;
   logic        long_bad;
   logic        range_bad;
   logic        field_bad;
   logic        value_bad;
   logic [31:0] len_mask;

   always_comb begin
      order_bad = end_bit < start_bit;
      diff      = {1'b0, end_bit} - {1'b0, start_bit};
      long_bad  = diff > 8'(hbfie_pkg::FIELD_MAX - 1);
      range_bad = 10'(end_bit) >= NB_BITS;
      field_bad = order_bad | long_bad | range_bad;
      len       = diff + 8'd1;
      if (len >= 8'(hbfie_pkg::FIELD_MAX)) begin
         len_mask = '1;
      end else begin
         len_mask = (32'd1 << len[4:0]) - 32'd1;
      end
      value_bad = |(field_value & ~len_mask);
      shamt     = LAST_BIT - SW'(end_bit);

      ctrl          = '0;
      ctrl.len_mask = len_mask;
      case (operation)
         hbfie_pkg::OP_CLEAR: begin
            ctrl.clr_en = 1'b1;
         end
         hbfie_pkg::OP_WRITE: begin
            ctrl.err   = field_bad | value_bad;
            ctrl.wr_en = ~(field_bad | value_bad);
         end
         hbfie_pkg::OP_READ: begin
            ctrl.err   = field_bad;
            ctrl.rd_en = ~field_bad;
         end
         default: begin
            ctrl.err = 1'b1;
         end
      endcase
   end

endmodule

// ===== design/hbfie_store.sv =====
// ----------------------------------------------------------------------------
// Header byte store
// Holds the header as one bit vector with bit 0 of the header in the top
// position, and performs masked field writes, field reads and clears.
// ----------------------------------------------------------------------------
module hbfie_store #(
   parameter int unsigned BUFFER_BYTES = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           enable,
   input  hbfie_pkg::ctrl_type                            ctrl,
   input  logic [$clog2(BUFFER_BYTES*hbfie_pkg::BYTE_BITS)-1:0] shamt,
   input  logic [31:0]                                    field_value,
   output logic [31:0]                                    rd_value
);

   localparam int unsigned NB = BUFFER_BYTES * hbfie_pkg::BYTE_BITS;

   logic [NB-1:0] store_ff;
   logic [NB-1:0] store_in;
   logic [NB-1:0] wr_mask;
   logic [NB-1:0] wr_data;

   always_comb begin
      wr_mask = NB'(ctrl.len_mask) << shamt;
      wr_data = NB'(field_value) << shamt;
      store_in = store_ff;
      if (ctrl.clr_en) begin
         store_in = '0;
      end else if (ctrl.wr_en) begin
         store_in = (store_ff & ~wr_mask) | (wr_data & wr_mask);
      end
      if (ctrl.rd_en) begin
         rd_value = 32'(store_ff >> shamt) & ctrl.len_mask;
      end else begin
         rd_value = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
      end else if (enable) begin
         store_ff <= store_in;
      end
   end

endmodule

// ===== design/header_bitfield_insert_extract_top.sv =====
// ----------------------------------------------------------------------------
// Header bit-field insert/extract
// Stream front end around the header store: input register, field check,
// store access and result register.
// ----------------------------------------------------------------------------
// The block keeps a header of BUFFER_BYTES bytes, numbered MSB-first, and
// takes one transaction per clock unless the result side stalls: clear,
// write a field of 1 to 32 bits, or read one back right-aligned. Each yields
// exactly one result via the input register, then the result register; the
// store is updated by the shift-and-mask path between them, so back-to-back
// transactions see each other's writes in order. Rejected fields or
// oversized write data raise error and leave the store unchanged.
module header_bitfield_insert_extract_top #(
   parameter int unsigned BUFFER_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // start_bit[6:0], end_bit[13:7], field_value[45:14]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_value[31:0]
   output logic        rsp_tuser    // error[0]
);

   localparam int unsigned NB = BUFFER_BYTES * hbfie_pkg::BYTE_BITS;
   localparam int unsigned SW = $clog2(NB);

   logic        s1_valid_ff;
   logic [1:0]  s1_op_ff;
   logic [6:0]  s1_start_ff;
   logic [6:0]  s1_end_ff;
   logic [31:0] s1_value_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        rsp_err_ff;

   logic                rsp_free;
   logic                advance;
   hbfie_pkg::ctrl_type ctrl;
   logic [SW-1:0]       shamt;
   logic [31:0]         rd_value;

   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign advance    = s1_valid_ff & rsp_free;
   assign req_tready = ~s1_valid_ff | rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready & req_tvalid) begin
         s1_op_ff    <= req_tuser;
         s1_start_ff <= req_tdata[6:0];
         s1_end_ff   <= req_tdata[13:7];
         s1_value_ff <= req_tdata[45:14];
      end
   end

   hbfie_check #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_check (
      .operation  (s1_op_ff),
      .start_bit  (s1_start_ff),
      .end_bit    (s1_end_ff),
      .field_value(s1_value_ff),
      .ctrl       (ctrl),
      .shamt      (shamt)
   );

   hbfie_store #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .enable     (advance),
      .ctrl       (ctrl),
      .shamt      (shamt),
      .field_value(s1_value_ff),
      .rd_value   (rd_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rd_value;
         rsp_err_ff  <= ctrl.err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

   a_err_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_data_ff == 32'd0))
      else $error("Rejected transaction carries nonzero read data.");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_free) |=> s1_valid_ff)
      else $error("Pending transaction dropped while the result was stalled.");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("Input stalled with an empty input register.");

   a_clear_ok: assert property (@(posedge clock) disable iff (reset)
      (advance && ctrl.clr_en) |=> !rsp_err_ff)
      else $error("Clear transaction reported an error.");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Header bit-field insert/extract testbench
// Drives clear, write and read transactions into the header store and checks
// every result against a local copy of the header bytes. Both stream sides
// idle and stall at random, and the sender sometimes waits for all results.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned HDR_BYTES    = 16;
   localparam int unsigned RANDOM_ITEMS = 1900;
   localparam int unsigned SETTLE_LIMIT = 16;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned REPORT_MAX   = 10;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;

   typedef struct {
      logic [1:0]  operation;
      logic [6:0]  start_bit;
      logic [6:0]  end_bit;
      logic [31:0] field_value;
      bit          drain_first;
   } hdr_access_type;

   typedef struct {
      logic [31:0] read_value;
      logic        error;
   } field_result_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   hdr_access_type   pending_accesses[$];
   field_result_type expected_results[$];
   hdr_access_type   access_on_bus;
   logic [7:0]       header_model[HDR_BYTES];

   int unsigned send_gap        = 0;
   int unsigned send_burst      = 0;
   int unsigned recv_stall      = 0;
   int unsigned recv_burst      = 0;
   int unsigned cycle_count     = 0;
   int unsigned mismatch_count  = 0;
   int unsigned results_checked = 0;
   int unsigned writes_sent     = 0;
   int unsigned reads_sent      = 0;
   int unsigned clears_sent     = 0;
   int unsigned rejects_sent    = 0;

   header_bitfield_insert_extract_top #(.BUFFER_BYTES(HDR_BYTES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   function automatic bit field_fits(int unsigned s, int unsigned e);
      if (e < s) return 1'b0;
      if (e - s + 1 > hbfie_pkg::FIELD_MAX) return 1'b0;
      if (e >= HDR_BYTES * hbfie_pkg::BYTE_BITS) return 1'b0;
      return 1'b1;
   endfunction

   // Updates the header copy and returns the result the block must produce.
   task automatic apply_header_access(input hdr_access_type acc,
                                      output field_result_type res);
      int unsigned s;
      int unsigned e;
      int unsigned len;
      logic [31:0] gathered;
      s = acc.start_bit;
      e = acc.end_bit;
      gathered = '0;
      res.read_value = '0;
      res.error = 1'b0;
      case (acc.operation)
         hbfie_pkg::OP_CLEAR: begin
            foreach (header_model[k]) header_model[k] = '0;
         end
         hbfie_pkg::OP_WRITE, hbfie_pkg::OP_READ: begin
            if (!field_fits(s, e)) begin
               res.error = 1'b1;
            end else begin
               len = e - s + 1;
               if (acc.operation == hbfie_pkg::OP_WRITE) begin
                  if (len < hbfie_pkg::FIELD_MAX && (acc.field_value >> len) != 0) begin
                     res.error = 1'b1;
                  end else begin
                     for (int unsigned p = s; p <= e; p++)
                        header_model[(p >> 3) % HDR_BYTES][7 - (p & 7)] =
                           acc.field_value[e - p];
                  end
               end else begin
                  for (int unsigned p = s; p <= e; p++)
                     gathered = {gathered[30:0],
                                 header_model[(p >> 3) % HDR_BYTES][7 - (p & 7)]};
                  res.read_value = gathered;
               end
            end
         end
         default: begin
            res.error = 1'b1;
         end
      endcase
   endtask

   // Mostly short gaps, a few long ones, and now and then a long run with none.
   function automatic int unsigned pick_idle(ref int unsigned burst_left);
      int unsigned r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 59) == 0) burst_left = $urandom_range(20, 80);
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] len_mask(int unsigned len);
      return (len >= 32) ? 32'hFFFF_FFFF : ((32'd1 << len) - 32'd1);
   endfunction

   task automatic queue_access(logic [1:0] op, int unsigned s, int unsigned e,
                               logic [31:0] v, bit drain = 1'b0);
      hdr_access_type acc;
      acc.operation   = op;
      acc.start_bit   = s[6:0];
      acc.end_bit     = e[6:0];
      acc.field_value = v;
      acc.drain_first = drain;
      pending_accesses.push_back(acc);
   endtask

   task automatic queue_random_access(bit drain);
      int unsigned sel;
      int unsigned len;
      int unsigned s;
      int unsigned e;
      logic [1:0]  op;
      sel = $urandom_range(0, 99);
      len = ($urandom_range(0, 4) == 0) ? 32 : $urandom_range(1, 32);
      s = $urandom_range(0, 128 - len);
      e = s + len - 1;
      op = $urandom_range(0, 1) ? hbfie_pkg::OP_WRITE : hbfie_pkg::OP_READ;
      if (sel < 4) begin
         queue_access(hbfie_pkg::OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom, drain);
      end else if (sel < 6) begin
         queue_access(OP_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127), $urandom, drain);
      end else if (sel < 46) begin
         queue_access(hbfie_pkg::OP_WRITE, s, e, $urandom & len_mask(len), drain);
      end else if (sel < 86) begin
         queue_access(hbfie_pkg::OP_READ, s, e, $urandom, drain);
      end else if (sel < 91) begin
         if (len == 32) len = $urandom_range(1, 31);
         e = s + len - 1;
         queue_access(hbfie_pkg::OP_WRITE, s, e,
                      ($urandom & len_mask(len)) | (32'd1 << $urandom_range(len, 31)), drain);
      end else if (sel < 95) begin
         s = $urandom_range(1, 127);
         queue_access(op, s, $urandom_range(0, s - 1), $urandom, drain);
      end else begin
         s = $urandom_range(0, 95);
         queue_access(op, s, $urandom_range(s + 32, 127), $urandom, drain);
      end
   endtask

   always @(posedge clock) begin
      field_result_type res;
      bit presenting;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         send_gap = 0;
         foreach (header_model[k]) header_model[k] = '0;
      end else begin
         presenting = req_tvalid;
         if (req_tvalid && req_tready) begin
            apply_header_access(access_on_bus, res);
            expected_results.push_back(res);
            if (res.error) rejects_sent++;
            else if (access_on_bus.operation == hbfie_pkg::OP_WRITE) writes_sent++;
            else if (access_on_bus.operation == hbfie_pkg::OP_READ) reads_sent++;
            else clears_sent++;
            presenting = 1'b0;
         end
         if (!presenting) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_accesses.size() > 0 &&
                         !(pending_accesses[0].drain_first && expected_results.size() != 0)) begin
               access_on_bus = pending_accesses.pop_front();
               req_tdata <= {2'b00, access_on_bus.field_value, access_on_bus.end_bit,
                             access_on_bus.start_bit};
               req_tuser <= access_on_bus.operation;
               presenting = 1'b1;
               send_gap = pick_idle(send_burst);
            end
         end
         req_tvalid <= presenting;
      end
   end

   always @(posedge clock) begin
      bit ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else begin
         ready_next = 1'b1;
         if (recv_stall > 0) begin
            recv_stall--;
            ready_next = 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            recv_stall = pick_idle(recv_burst);
            ready_next = (recv_stall == 0);
         end
         rsp_tready <= ready_next;
      end
   end

   always @(posedge clock) begin
      field_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("[%0t] Result with no transaction pending: read_value %h error %b",
                        $realtime, rsp_tdata, rsp_tuser);
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (rsp_tdata !== want.read_value || rsp_tuser !== want.error) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("[%0t] Result %0d: expected read_value %h error %b, got %h %b",
                           $realtime, results_checked, want.read_value, want.error,
                           rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned settle;
      queue_access(hbfie_pkg::OP_READ,   0,  31, 32'h0);
      queue_access(hbfie_pkg::OP_WRITE,  0,   0, 32'h1);
      queue_access(hbfie_pkg::OP_WRITE, 127, 127, 32'h1);
      queue_access(hbfie_pkg::OP_READ,   0,  31, 32'h0);
      queue_access(hbfie_pkg::OP_READ,  96, 127, 32'h0);
      queue_access(hbfie_pkg::OP_WRITE,  3,  34, 32'hFFFF_FFFF);
      queue_access(hbfie_pkg::OP_READ,   0,  31, 32'h0);
      queue_access(hbfie_pkg::OP_READ,   3,  34, 32'h0);
      queue_access(hbfie_pkg::OP_WRITE, 41,  46, 32'h2A);
      queue_access(hbfie_pkg::OP_READ,  40,  47, 32'h0);
      queue_access(hbfie_pkg::OP_WRITE, 96, 127, 32'h0);
      queue_access(hbfie_pkg::OP_READ,  95, 126, 32'h0);
      queue_access(hbfie_pkg::OP_WRITE,  0,  32, 32'h1);
      queue_access(hbfie_pkg::OP_READ,  10,   9, 32'h0);
      queue_access(hbfie_pkg::OP_WRITE, 20,  27, 32'h100);
      queue_access(hbfie_pkg::OP_WRITE, 20,  27, 32'h8000_0000);
      queue_access(OP_UNUSED, 127, 127, 32'hFFFF_FFFF);
      queue_access(hbfie_pkg::OP_READ,   0,  31, 32'h0);
      queue_access(hbfie_pkg::OP_CLEAR, 127,  0, 32'hFFFF_FFFF);
      queue_access(hbfie_pkg::OP_READ,   3,  34, 32'h0, 1'b1);
      queue_access(hbfie_pkg::OP_WRITE, 64,  95, 32'hA5A5_A5A5);
      queue_access(hbfie_pkg::OP_READ,  64,  95, 32'h0);
      queue_access(hbfie_pkg::OP_READ, 127, 127, 32'h0);
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
         queue_random_access(n % 300 == 299);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_accesses.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      settle = 0;
      while (settle < SETTLE_LIMIT) begin
         @(posedge clock);
         settle++;
      end

      $display("Checked %0d results: %0d writes, %0d reads, %0d clears, %0d rejected.",
               results_checked, writes_sent, reads_sent, clears_sent, rejects_sent);
      $display("Traffic ran with random gaps and stalls on both sides; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
